FILE: hw/rtl/gradient_band_fill_defines.svh
// ----------------------------------------------------------------------------
// Gradient band fill assertion macros
// Shared property shapes for the port checker, clocked on clk, off in reset.
// ----------------------------------------------------------------------------
`ifndef GRADIENT_BAND_FILL_DEFINES_SVH
`define GRADIENT_BAND_FILL_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define GBF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define GBF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/gbf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gradient band fill package
// Register map, direction and emit codes, and the controller/datapath bundles.
// ----------------------------------------------------------------------------
package gbf_pkg;

  // configuration port
  localparam int ADDR_W     = 4;
  localparam int DATA_W     = 32;
  localparam int COLOR_W    = 24;
  localparam int CHAN_W     = 8;
  localparam int BAND_CNT_W = 6;
  localparam int NUM_CHAN   = 3;

  // fewest bands that make a gradient
  localparam int MIN_BANDS = 2;

  typedef logic [1:0] reg_idx_t;
  localparam reg_idx_t REG_START_COLOR = 2'd0;
  localparam reg_idx_t REG_END_COLOR   = 2'd1;
  localparam reg_idx_t REG_DIRECTION   = 2'd2;
  localparam reg_idx_t REG_BAND_COUNT  = 2'd3;

  localparam logic [COLOR_W-1:0]    START_COLOR_RST = 24'h000000;
  localparam logic [COLOR_W-1:0]    END_COLOR_RST   = 24'hFFFFFF;
  localparam logic [BAND_CNT_W-1:0] BAND_COUNT_RST  = 6'd2;

  typedef logic [1:0] dir_t;
  localparam dir_t DIR_DOWN  = 2'd0;
  localparam dir_t DIR_UP    = 2'd1;
  localparam dir_t DIR_RIGHT = 2'd2;
  localparam dir_t DIR_LEFT  = 2'd3;

  typedef logic [1:0] emit_kind_t;
  localparam emit_kind_t EMIT_SINGLE = 2'd0;
  localparam emit_kind_t EMIT_BAND   = 2'd1;
  localparam emit_kind_t EMIT_REM    = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic       capture;
    logic       div_load;
    logic       div_step;
    logic       band_init;
    logic       emit;
    emit_kind_t kind;
  } gbf_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic empty;
    logic single;
    logic has_bands;
    logic rem_nz;
    logic band_last;
    logic out_free;
  } gbf_stat_t;

endpackage

FILE: hw/rtl/gbf_rect_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rectangle channel
// Valid/ready channel carrying one rectangle word.
// ----------------------------------------------------------------------------
interface gbf_rect_if #(
  parameter int COORD_WIDTH = 12
);
  logic                   valid;
  logic                   ready;
  logic [COORD_WIDTH-1:0] rect_left;
  logic [COORD_WIDTH-1:0] rect_top;
  logic [COORD_WIDTH-1:0] rect_right;
  logic [COORD_WIDTH-1:0] rect_bottom;

  modport source (output valid, rect_left, rect_top, rect_right, rect_bottom, input ready);
  modport sink   (input valid, rect_left, rect_top, rect_right, rect_bottom, output ready);
endinterface

FILE: hw/rtl/gbf_band_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Band channel
// Valid/ready channel carrying one band word: edges, colour and last flag.
// ----------------------------------------------------------------------------
interface gbf_band_if #(
  parameter int COORD_WIDTH = 12
);
  logic                   valid;
  logic                   ready;
  logic [COORD_WIDTH-1:0] band_left;
  logic [COORD_WIDTH-1:0] band_top;
  logic [COORD_WIDTH-1:0] band_right;
  logic [COORD_WIDTH-1:0] band_bottom;
  logic [7:0]             red;
  logic [7:0]             green;
  logic [7:0]             blue;
  logic                   last;

  modport source (output valid, band_left, band_top, band_right, band_bottom,
                  red, green, blue, last, input ready);
  modport sink   (input valid, band_left, band_top, band_right, band_bottom,
                  red, green, blue, last, output ready);
endinterface

FILE: hw/rtl/gbf_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gradient band fill divider lane
// Restoring unsigned divider, one quotient bit per step.
// ----------------------------------------------------------------------------
module gbf_div #(
  parameter int DIV_W = 12,
  parameter int DEN_W = 6
) (
  input  logic             clk,
  input  logic             load,
  input  logic             step,
  input  logic [DIV_W-1:0] dividend,
  input  logic [DEN_W-1:0] divisor,
  output logic [DIV_W-1:0] quo,
  output logic [DEN_W-1:0] rem
);

  logic [DEN_W-1:0] den;
  logic [DEN_W:0]   shifted;
  logic [DEN_W:0]   diff;
  logic             ge;

  // trial subtract of the divisor from the partial remainder
  assign shifted = {rem, quo[DIV_W-1]};
  assign diff    = shifted - {1'b0, den};
  assign ge      = shifted >= {1'b0, den};

  // load operands, then shift one bit a step
  always_ff @(posedge clk) begin
    if (load) begin
      den <= divisor;
      quo <= dividend;
      rem <= '0;
    end else if (step) begin
      quo <= {quo[DIV_W-2:0], ge};
      rem <= ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
    end
  end

endmodule

FILE: hw/rtl/gbf_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gradient band fill controller
// Sequences capture, divide, band stepping and output loads for one rectangle.
// ----------------------------------------------------------------------------
module gbf_ctrl #(
  parameter int DIV_W = 12
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               rect_valid,
  output logic               rect_ready,
  input  gbf_pkg::gbf_stat_t stat,
  output gbf_pkg::gbf_cmd_t  cmd
);
  import gbf_pkg::*;

  localparam int CTR_W = $clog2(DIV_W);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SETUP  = 3'd1;
  localparam logic [2:0] ST_SINGLE = 3'd2;
  localparam logic [2:0] ST_DIV    = 3'd3;
  localparam logic [2:0] ST_INIT   = 3'd4;
  localparam logic [2:0] ST_BANDS  = 3'd5;
  localparam logic [2:0] ST_REM    = 3'd6;

  logic [2:0]       state;
  logic [2:0]       state_next;
  logic [CTR_W-1:0] ctr;
  logic [CTR_W-1:0] ctr_next;

  assign rect_ready = (state == ST_IDLE);

  // next state and commands
  always_comb begin
    state_next = state;
    ctr_next   = ctr;
    cmd        = '0;
    cmd.kind   = EMIT_BAND;
    case (state)
      ST_IDLE: begin
        if (rect_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_SETUP;
        end
      end
      ST_SETUP: begin
        if (stat.empty) begin
          state_next = ST_IDLE;
        end else if (stat.single) begin
          state_next = ST_SINGLE;
        end else begin
          cmd.div_load = 1'b1;
          ctr_next     = '0;
          state_next   = ST_DIV;
        end
      end
      ST_SINGLE: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          cmd.kind   = EMIT_SINGLE;
          state_next = ST_IDLE;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        ctr_next     = ctr + 1'b1;
        if (ctr == CTR_W'(DIV_W - 1)) begin
          state_next = ST_INIT;
        end
      end
      ST_INIT: begin
        cmd.band_init = 1'b1;
        if (stat.has_bands) begin
          state_next = ST_BANDS;
        end else if (stat.rem_nz) begin
          state_next = ST_REM;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_BANDS: begin
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          cmd.kind = EMIT_BAND;
          if (stat.band_last) begin
            state_next = stat.rem_nz ? ST_REM : ST_IDLE;
          end
        end
      end
      ST_REM: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          cmd.kind   = EMIT_REM;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // state and step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      ctr   <= '0;
    end else begin
      state <= state_next;
      ctr   <= ctr_next;
    end
  end

endmodule

FILE: hw/rtl/gbf_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gradient band fill datapath
// Rectangle capture, four divider lanes, band/colour stepping, output register.
// ----------------------------------------------------------------------------
module gbf_dp #(
  parameter int MAX_BANDS   = 32,
  parameter int COORD_WIDTH = 12,
  parameter int CNT_W       = 6,
  parameter int DIV_W       = 12
) (
  input  logic                            clk,
  input  logic                            rst,
  input  gbf_pkg::gbf_cmd_t               cmd,
  output gbf_pkg::gbf_stat_t              stat,
  input  logic [COORD_WIDTH-1:0]          in_left,
  input  logic [COORD_WIDTH-1:0]          in_top,
  input  logic [COORD_WIDTH-1:0]          in_right,
  input  logic [COORD_WIDTH-1:0]          in_bottom,
  input  logic [gbf_pkg::COLOR_W-1:0]     start_color,
  input  logic [gbf_pkg::COLOR_W-1:0]     end_color,
  input  gbf_pkg::dir_t                   direction,
  input  logic [gbf_pkg::BAND_CNT_W-1:0]  band_count,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [COORD_WIDTH-1:0]          band_left,
  output logic [COORD_WIDTH-1:0]          band_top,
  output logic [COORD_WIDTH-1:0]          band_right,
  output logic [COORD_WIDTH-1:0]          band_bottom,
  output logic [gbf_pkg::CHAN_W-1:0]      red,
  output logic [gbf_pkg::CHAN_W-1:0]      green,
  output logic [gbf_pkg::CHAN_W-1:0]      blue,
  output logic                            last
);
  import gbf_pkg::*;

  localparam int CMP_W = (COORD_WIDTH > CNT_W) ? COORD_WIDTH : CNT_W;
  localparam int LANES = NUM_CHAN + 1;

  logic [COORD_WIDTH-1:0] l_q, t_q, r_q, b_q;
  logic                   vert;
  logic                   swap;
  logic [COLOR_W-1:0]     c0, c1;
  logic [CNT_W-1:0]       req_cnt;
  logic [CNT_W-1:0]       cnt_fit;
  logic [COORD_WIDTH-1:0] span;
  logic [COORD_WIDTH-1:0] base;
  logic [COORD_WIDTH-1:0] far_edge;
  logic [CNT_W-1:0]       cnt_q;
  logic [CNT_W-1:0]       den;

  logic [DIV_W-1:0]       div_dvd [LANES];
  logic [CNT_W-1:0]       div_dsr [LANES];
  logic [DIV_W-1:0]       div_quo [LANES];
  logic [CNT_W-1:0]       div_rem [LANES];

  logic [COORD_WIDTH-1:0] width;
  logic [COORD_WIDTH-1:0] rem_w;
  logic [CNT_W-1:0]       idx;
  logic [COORD_WIDTH-1:0] pos;
  logic [CHAN_W-1:0]      acc_q [NUM_CHAN];
  logic [CNT_W-1:0]       acc_r [NUM_CHAN];
  logic [CHAN_W-1:0]      chan_s [NUM_CHAN];
  logic [CHAN_W-1:0]      chan_e [NUM_CHAN];
  logic [CHAN_W-1:0]      chan_v [NUM_CHAN];
  logic [CNT_W:0]         acc_sum [NUM_CHAN];
  logic                   acc_wrap [NUM_CHAN];

  // rectangle capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      l_q <= in_left;
      t_q <= in_top;
      r_q <= in_right;
      b_q <= in_bottom;
    end
  end

  // orientation and colour order
  assign vert = (direction == DIR_DOWN) || (direction == DIR_UP);
  assign swap = (direction == DIR_UP) || (direction == DIR_LEFT);
  assign c0   = swap ? end_color : start_color;
  assign c1   = swap ? start_color : end_color;

  assign span     = vert ? (b_q - t_q) : (r_q - l_q);
  assign base     = vert ? t_q : l_q;
  assign far_edge = vert ? b_q : r_q;

  // requested count saturated, then fitted to the span with a floor of two
  always_comb begin
    if (band_count > BAND_CNT_W'(MAX_BANDS)) begin
      req_cnt = CNT_W'(MAX_BANDS);
    end else begin
      req_cnt = CNT_W'(band_count);
    end
    if (CMP_W'(span) < CMP_W'(req_cnt)) begin
      cnt_fit = CNT_W'(span);
    end else begin
      cnt_fit = req_cnt;
    end
    if (cnt_fit < CNT_W'(MIN_BANDS)) begin
      cnt_fit = CNT_W'(MIN_BANDS);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      cnt_q <= cnt_fit;
    end
  end
  assign den = cnt_q - 1'b1;

  // lane 0 splits the span, lanes 1..3 split each channel step by count-1
  assign div_dvd[0] = DIV_W'(span);
  assign div_dsr[0] = cnt_fit;

  genvar g;
  generate
    for (g = 0; g < NUM_CHAN; g++) begin : g_chan
      logic [CHAN_W-1:0] abs_d;
      assign chan_s[g] = c0[CHAN_W*g +: CHAN_W];
      assign chan_e[g] = c1[CHAN_W*g +: CHAN_W];
      assign abs_d     = (chan_e[g] > chan_s[g]) ? (chan_e[g] - chan_s[g])
                                                 : (chan_s[g] - chan_e[g]);
      assign div_dvd[g+1] = DIV_W'(abs_d);
      assign div_dsr[g+1] = cnt_fit - 1'b1;

      // running quotient and remainder of i*|d| + floor(den/2) over den
      assign acc_sum[g]  = {1'b0, acc_r[g]} + {1'b0, div_rem[g+1]};
      assign acc_wrap[g] = acc_sum[g] >= {1'b0, den};
      assign chan_v[g]   = (chan_e[g] < chan_s[g]) ? (chan_s[g] - acc_q[g])
                                                   : (chan_s[g] + acc_q[g]);

      always_ff @(posedge clk) begin
        if (cmd.band_init) begin
          acc_q[g] <= '0;
          acc_r[g] <= den >> 1;
        end else if (cmd.emit && (cmd.kind == EMIT_BAND)) begin
          if (acc_wrap[g]) begin
            acc_r[g] <= CNT_W'(acc_sum[g] - {1'b0, den});
            acc_q[g] <= acc_q[g] + div_quo[g+1][CHAN_W-1:0] + 1'b1;
          end else begin
            acc_r[g] <= acc_sum[g][CNT_W-1:0];
            acc_q[g] <= acc_q[g] + div_quo[g+1][CHAN_W-1:0];
          end
        end
      end
    end

    for (g = 0; g < LANES; g++) begin : g_lane
      gbf_div #(
        .DIV_W (DIV_W),
        .DEN_W (CNT_W)
      ) u_div (
        .clk      (clk),
        .load     (cmd.div_load),
        .step     (cmd.div_step),
        .dividend (div_dvd[g]),
        .divisor  (div_dsr[g]),
        .quo      (div_quo[g]),
        .rem      (div_rem[g])
      );
    end
  endgenerate

  assign width = div_quo[0][COORD_WIDTH-1:0];
  assign rem_w = COORD_WIDTH'(div_rem[0]);

  // band position and index
  always_ff @(posedge clk) begin
    if (cmd.band_init) begin
      idx <= '0;
      pos <= base;
    end else if (cmd.emit && (cmd.kind == EMIT_BAND)) begin
      idx <= idx + 1'b1;
      pos <= pos + width;
    end
  end

  // status
  assign stat.empty     = (r_q <= l_q) || (b_q <= t_q);
  assign stat.single    = req_cnt < CNT_W'(MIN_BANDS);
  assign stat.has_bands = (width != '0);
  assign stat.rem_nz    = (rem_w != '0);
  assign stat.band_last = (idx == den);
  assign stat.out_free  = !out_valid || out_ready;

  // output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // output word
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      case (cmd.kind)
        EMIT_SINGLE: begin
          band_left   <= l_q;
          band_top    <= t_q;
          band_right  <= r_q;
          band_bottom <= b_q;
          red         <= start_color[CHAN_W*0 +: CHAN_W];
          green       <= start_color[CHAN_W*1 +: CHAN_W];
          blue        <= start_color[CHAN_W*2 +: CHAN_W];
          last        <= 1'b1;
        end
        EMIT_BAND: begin
          band_left   <= vert ? l_q : pos;
          band_top    <= vert ? pos : t_q;
          band_right  <= vert ? r_q : (pos + width);
          band_bottom <= vert ? (pos + width) : b_q;
          red         <= chan_v[0];
          green       <= chan_v[1];
          blue        <= chan_v[2];
          last        <= (idx == den) && (rem_w == '0);
        end
        EMIT_REM: begin
          band_left   <= vert ? l_q : (far_edge - rem_w);
          band_top    <= vert ? (far_edge - rem_w) : t_q;
          band_right  <= r_q;
          band_bottom <= b_q;
          red         <= c1[CHAN_W*0 +: CHAN_W];
          green       <= c1[CHAN_W*1 +: CHAN_W];
          blue        <= c1[CHAN_W*2 +: CHAN_W];
          last        <= 1'b1;
        end
        default: begin
          last <= 1'b1;
        end
      endcase
    end
  end

endmodule

FILE: hw/rtl/gradient_band_fill.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gradient band fill
// One rectangle word in gives the solid colour bands of a linear gradient
// across it, top or left band first, the final word flagged by last. A
// rectangle is taken when the block is idle; it is captured on acceptance,
// then a setup state drops an empty rectangle or sends a single band on to
// its own state. Otherwise the span and the three colour steps are split by
// a bank of bit-serial dividers, the band stepper is primed, and then one
// band word is loaded per cycle while the output register is free, with a
// remainder strip last when the span leaves one. The output register lets
// the next rectangle be taken while the final band word still waits.
// Registers sit on an APB port at byte offsets 0, 4, 8 and 12.
// ----------------------------------------------------------------------------
module gradient_band_fill #(
  parameter int MAX_BANDS   = 32,
  parameter int COORD_WIDTH = 12
) (
  input  logic                         clk,
  input  logic                         rst,
  gbf_rect_if.sink                     rect,
  gbf_band_if.source                   band,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [gbf_pkg::ADDR_W-1:0]   paddr,
  input  logic [gbf_pkg::DATA_W-1:0]   pwdata,
  output logic [gbf_pkg::DATA_W-1:0]   prdata,
  output logic                         pready
);
  import gbf_pkg::*;

  localparam int CNT_W = $clog2(MAX_BANDS + 1);
  localparam int DIV_W = (COORD_WIDTH > CHAN_W) ? COORD_WIDTH : CHAN_W;

  logic [COLOR_W-1:0]    start_color;
  logic [COLOR_W-1:0]    end_color;
  dir_t                  direction;
  logic [BAND_CNT_W-1:0] band_count;
  reg_idx_t              reg_idx;
  logic                  wr_en;
  gbf_cmd_t              cmd;
  gbf_stat_t             stat;

  // configuration registers
  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_color <= START_COLOR_RST;
      end_color   <= END_COLOR_RST;
      direction   <= DIR_DOWN;
      band_count  <= BAND_COUNT_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_START_COLOR: start_color <= pwdata[COLOR_W-1:0];
        REG_END_COLOR:   end_color   <= pwdata[COLOR_W-1:0];
        REG_DIRECTION:   direction   <= pwdata[1:0];
        REG_BAND_COUNT:  band_count  <= pwdata[BAND_CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // register readback
  always_comb begin
    case (reg_idx)
      REG_START_COLOR: prdata = DATA_W'(start_color);
      REG_END_COLOR:   prdata = DATA_W'(end_color);
      REG_DIRECTION:   prdata = DATA_W'(direction);
      REG_BAND_COUNT:  prdata = DATA_W'(band_count);
      default:         prdata = '0;
    endcase
  end

  // sequencer
  gbf_ctrl #(
    .DIV_W (DIV_W)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .rect_valid (rect.valid),
    .rect_ready (rect.ready),
    .stat       (stat),
    .cmd        (cmd)
  );

  // datapath
  gbf_dp #(
    .MAX_BANDS   (MAX_BANDS),
    .COORD_WIDTH (COORD_WIDTH),
    .CNT_W       (CNT_W),
    .DIV_W       (DIV_W)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .in_left     (rect.rect_left),
    .in_top      (rect.rect_top),
    .in_right    (rect.rect_right),
    .in_bottom   (rect.rect_bottom),
    .start_color (start_color),
    .end_color   (end_color),
    .direction   (direction),
    .band_count  (band_count),
    .out_valid   (band.valid),
    .out_ready   (band.ready),
    .band_left   (band.band_left),
    .band_top    (band.band_top),
    .band_right  (band.band_right),
    .band_bottom (band.band_bottom),
    .red         (band.red),
    .green       (band.green),
    .blue        (band.blue),
    .last        (band.last)
  );

endmodule

FILE: hw/rtl/gbf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gradient band fill port checker
// Watches the rectangle and band channels of the top level.
// ----------------------------------------------------------------------------
`include "gradient_band_fill_defines.svh"

module gbf_checker #(
  parameter int COORD_WIDTH = 12
) (
  input logic                   clk,
  input logic                   rst,
  input logic                   rect_valid,
  input logic                   rect_ready,
  input logic                   band_valid,
  input logic                   band_ready,
  input logic [COORD_WIDTH-1:0] band_left,
  input logic [COORD_WIDTH-1:0] band_top,
  input logic [COORD_WIDTH-1:0] band_right,
  input logic [COORD_WIDTH-1:0] band_bottom,
  input logic [7:0]             red,
  input logic [7:0]             green,
  input logic [7:0]             blue,
  input logic                   last
);

  logic [4*COORD_WIDTH+24:0] band_word;

  assign band_word = {band_left, band_top, band_right, band_bottom, red, green, blue, last};

  // a stalled band word stays put
  `GBF_ASSERT_NEXT(a_band_hold, band_valid && !band_ready, band_valid && $stable(band_word), "band word changed while stalled")

  // one rectangle at a time: busy right after taking one
  `GBF_ASSERT_NEXT(a_rect_busy, rect_valid && rect_ready, !rect_ready, "rectangle taken while busy")

  // every band covers at least one pixel in each direction
  `GBF_ASSERT_NOW(a_band_nonempty, band_valid, (band_left < band_right) && (band_top < band_bottom), "empty band emitted")

endmodule

bind gradient_band_fill gbf_checker #(
  .COORD_WIDTH (COORD_WIDTH)
) u_gbf_checker (
  .clk         (clk),
  .rst         (rst),
  .rect_valid  (rect.valid),
  .rect_ready  (rect.ready),
  .band_valid  (band.valid),
  .band_ready  (band.ready),
  .band_left   (band.band_left),
  .band_top    (band.band_top),
  .band_right  (band.band_right),
  .band_bottom (band.band_bottom),
  .red         (band.red),
  .green       (band.green),
  .blue        (band.blue),
  .last        (band.last)
);
